[rtl/sem_pkg.sv]
// Shared types and constants for the Sobel edge magnitude stream.
// Used by the top level, sem_window and sem_out_fifo; depends on nothing else.
package sem_pkg;

  // Field types at the widths of the stream payload.
  typedef logic [7:0]  pix_t;
  typedef logic [11:0] row_t;
  typedef logic [9:0]  col_t;

  // Configuration port geometry and register indexes.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMG_WIDTH     = 2'd0,
    CFG_IMG_HEIGHT    = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } cfg_idx_e;

  // Register values after reset.
  localparam logic [10:0] IMG_WIDTH_RST     = 11'd640;
  localparam logic [12:0] IMG_HEIGHT_RST    = 13'd480;
  localparam logic [2:0]  CHANNEL_COUNT_RST = 3'd3;

  // Gray weights as 16-bit fractions of 0.299, 0.587 and 0.114.
  localparam logic [15:0] GRAY_COEF_R = 16'd19595;
  localparam logic [15:0] GRAY_COEF_G = 16'd38470;
  localparam logic [15:0] GRAY_COEF_B = 16'd7471;

  // Largest edge value after the divide by four.
  localparam logic [7:0] EDGE_MAX = 8'd255;

  // One pixel causes at most this many result beats.
  localparam int unsigned RES_PER_ITEM = 3;

  // Result queue depth, a power of two.
  localparam int unsigned FIFO_DEPTH = 8;

  // One line store entry: the pixel two rows up and the one a row up.
  typedef struct packed {
    pix_t top;
    pix_t mid;
  } line_entry_t;

  // What an accepted pixel is to emit, worked out from its position.
  typedef struct packed {
    row_t row_cur;
    row_t row_prev;
    col_t col_cur;
    col_t col_prev;
    logic emit_a;
    logic emit_b;
    logic emit_c;
    logic interior;
    logic last_col;
  } item_ctrl_t;

  // One result beat.
  typedef struct packed {
    pix_t edge_value;
    col_t col;
    row_t row;
    logic frame_last;
  } result_t;

endpackage

[rtl/sobel_edge_magnitude_stream.sv]
// Top level of the Sobel edge magnitude stream.
// Depends on sem_pkg, sem_ram, sem_window and sem_out_fifo.
//
// Takes one RGB pixel per clock in raster order and returns, per pixel of
// the frame, one beat with its row, column and min(255, (|Gx|+|Gy|)/4) of
// the gray 3x3 neighborhood (zero on the border, and everywhere when the
// width or height is under three). A pixel's result leaves once its lower
// right neighbor has arrived; the last row leaves as it arrives, and tlast
// marks the final beat of the frame. Pixels flow through three register
// stages (input and line store read, gray and window update, result queue)
// before their beats leave. The block sustains one pixel per cycle; its
// input is held off only while the eight-entry result queue, counting beats
// of pixels still in flight, has fewer than three free slots, which happens
// when the output side stalls or along the last row, where each pixel yields
// two beats and the row end three. The line store is one MAX_WIDTH by 16-bit
// RAM with one read and one write port; it needs no clearing after reset. A
// configuration write to one of the three registers restarts the frame.
module sobel_edge_magnitude_stream #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Pixel input.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [23:0]                     s_axis_tdata,  // red, green, blue
  // Result output.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [31:0]                     m_axis_tdata,  // out_row, out_col, edge_value
  output logic                            m_axis_tlast,  // frame_last
  // Configuration writes.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sem_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  // Configuration registers.
  logic [10:0] cfg_width_q;
  logic [12:0] cfg_height_q;
  logic [2:0]  cfg_channels_q;
  logic        cfg_hit;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_valid_i) begin
      case (sem_pkg::cfg_idx_e'(cfg_index_i))
        sem_pkg::CFG_IMG_WIDTH:     cfg_hit = 1'b1;
        sem_pkg::CFG_IMG_HEIGHT:    cfg_hit = 1'b1;
        sem_pkg::CFG_CHANNEL_COUNT: cfg_hit = 1'b1;
        default:                    cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q    <= sem_pkg::IMG_WIDTH_RST;
      cfg_height_q   <= sem_pkg::IMG_HEIGHT_RST;
      cfg_channels_q <= sem_pkg::CHANNEL_COUNT_RST;
    end else if (cfg_valid_i) begin
      case (sem_pkg::cfg_idx_e'(cfg_index_i))
        sem_pkg::CFG_IMG_WIDTH:     cfg_width_q    <= cfg_data_i[10:0];
        sem_pkg::CFG_IMG_HEIGHT:    cfg_height_q   <= cfg_data_i[12:0];
        sem_pkg::CFG_CHANNEL_COUNT: cfg_channels_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Frame size with zero taken as one and large values held at the maximum.
  logic [CW:0] w_eff;
  logic [RW:0] h_eff;
  logic        big;

  always_comb begin
    if (cfg_width_q == '0) begin
      w_eff = (CW+1)'(1);
    end else if (32'(cfg_width_q) > 32'(MAX_WIDTH)) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(cfg_width_q);
    end
    if (cfg_height_q == '0) begin
      h_eff = (RW+1)'(1);
    end else if (32'(cfg_height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = (RW+1)'(MAX_HEIGHT);
    end else begin
      h_eff = (RW+1)'(cfg_height_q);
    end
    big = (w_eff >= (CW+1)'(3)) && (h_eff >= (RW+1)'(3));
  end

  // Position of the next pixel.
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          last_col, last_row, s_acc;

  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign last_col = ((CW+1)'(col_q) + (CW+1)'(1)) == w_eff;
  assign last_row = ((RW+1)'(row_q) + (RW+1)'(1)) == h_eff;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (s_acc) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Which beats this pixel causes.
  sem_pkg::item_ctrl_t ctrl;
  logic [1:0]          reserve;

  always_comb begin
    ctrl.row_cur  = sem_pkg::row_t'(row_q);
    ctrl.row_prev = sem_pkg::row_t'(row_q - RW'(1));
    ctrl.col_cur  = sem_pkg::col_t'(col_q);
    ctrl.col_prev = sem_pkg::col_t'(col_q - CW'(1));
    ctrl.emit_a   = (row_q != '0) && (col_q != '0);
    ctrl.emit_b   = (row_q != '0) && last_col;
    ctrl.emit_c   = last_row;
    ctrl.interior = big && (row_q >= RW'(2)) && (col_q >= CW'(2));
    ctrl.last_col = last_col;
    reserve = s_acc ? (2'(ctrl.emit_a) + 2'(ctrl.emit_b) + 2'(ctrl.emit_c)) : 2'd0;
  end

  // Stage one: pixel registered while the line store is read.
  logic                s1_valid_q, s1_fwd_q;
  sem_pkg::item_ctrl_t s1_ctrl_q;
  sem_pkg::pix_t       s1_red_q, s1_green_q, s1_blue_q;
  logic [CW-1:0]       s1_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_fwd_q   <= 1'b0;
    end else begin
      s1_valid_q <= s_acc;
      s1_fwd_q   <= s_acc && s1_valid_q && (s1_addr_q == col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_ctrl_q  <= ctrl;
      s1_red_q   <= s_axis_tdata[7:0];
      s1_green_q <= s_axis_tdata[15:8];
      s1_blue_q  <= s_axis_tdata[23:16];
      s1_addr_q  <= col_q;
    end
  end

  // Line store and window.
  sem_pkg::line_entry_t ram_rdata, ram_wdata;
  sem_pkg::pix_t        magnitude;

  sem_ram #(
    .WIDTH ($bits(sem_pkg::line_entry_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (ram_wdata),
    .re_i    (s_acc),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  sem_window u_window (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (s1_valid_q),
    .red_i           (s1_red_q),
    .green_i         (s1_green_q),
    .blue_i          (s1_blue_q),
    .channel_count_i (cfg_channels_q),
    .ram_rdata_i     (ram_rdata),
    .fwd_i           (s1_fwd_q),
    .ram_wdata_o     (ram_wdata),
    .magnitude_o     (magnitude)
  );

  // Stage two: the window now holds this pixel's neighborhood.
  logic                s2_valid_q;
  sem_pkg::item_ctrl_t s2_ctrl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_ctrl_q <= s1_ctrl_q;
    end
  end

  // Beats in emission order: upper-left neighbor, row end, last row.
  sem_pkg::result_t [sem_pkg::RES_PER_ITEM-1:0] push_data;
  logic [sem_pkg::RES_PER_ITEM-1:0]             push_valid;

  always_comb begin
    push_data[0].row        = s2_ctrl_q.row_prev;
    push_data[0].col        = s2_ctrl_q.col_prev;
    push_data[0].edge_value = s2_ctrl_q.interior ? magnitude : '0;
    push_data[0].frame_last = 1'b0;
    push_data[1].row        = s2_ctrl_q.row_prev;
    push_data[1].col        = s2_ctrl_q.col_cur;
    push_data[1].edge_value = '0;
    push_data[1].frame_last = 1'b0;
    push_data[2].row        = s2_ctrl_q.row_cur;
    push_data[2].col        = s2_ctrl_q.col_cur;
    push_data[2].edge_value = '0;
    push_data[2].frame_last = s2_ctrl_q.last_col;
    push_valid = s2_valid_q ? {s2_ctrl_q.emit_c, s2_ctrl_q.emit_b, s2_ctrl_q.emit_a}
                            : '0;
  end

  // Result queue and output beat.
  sem_pkg::result_t head;
  logic             can_reserve;

  sem_out_fifo u_out_fifo (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .reserve_i     (reserve),
    .push_valid_i  (push_valid),
    .push_data_i   (push_data),
    .pop_i         (m_axis_tvalid && m_axis_tready),
    .can_reserve_o (can_reserve),
    .head_valid_o  (m_axis_tvalid),
    .head_o        (head)
  );

  assign s_axis_tready = can_reserve;
  assign m_axis_tdata  = {2'b00, head.edge_value, head.col, head.row};
  assign m_axis_tlast  = head.frame_last;

`ifndef SYNTH
  // A read can only miss the previous write when each row is one pixel.
  a_fwd_only_narrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_fwd_q) |-> (w_eff == (CW+1)'(1)))
    else $error("line store forwarding used with a row wider than one pixel");

  // The final beat of a frame lies on the bottom border.
  a_last_is_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[29:22] == 8'd0))
    else $error("frame-final beat carries a nonzero edge value");

  // Nonzero edges never sit on the top row or left column.
  a_edge_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[29:22] != 8'd0))
      |-> ((m_axis_tdata[11:0] != 12'd0) && (m_axis_tdata[21:12] != 10'd0)))
    else $error("nonzero edge value on the top row or left column");

  // Input is held off only while beats are pending somewhere.
  a_stall_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid || s1_valid_q || s2_valid_q))
    else $error("input stalled with nothing pending");
`endif

endmodule

[rtl/sem_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the gray line store.
module sem_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; returns the old word on a same-address write.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/sem_window.sv]
// Gray conversion, line store update data and the 3x3 gray window,
// plus the Sobel magnitude of the window. Uses sem_pkg.
module sem_window (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  sem_pkg::pix_t         red_i,
  input  sem_pkg::pix_t         green_i,
  input  sem_pkg::pix_t         blue_i,
  input  logic [2:0]            channel_count_i,
  input  sem_pkg::line_entry_t  ram_rdata_i,
  input  logic                  fwd_i,
  output sem_pkg::line_entry_t  ram_wdata_o,
  output sem_pkg::pix_t         magnitude_o
);

  sem_pkg::pix_t        win_q [3][3];
  sem_pkg::line_entry_t last_wr_q;
  sem_pkg::line_entry_t entry;
  sem_pkg::pix_t        gray;
  logic [23:0]          gray_sum;

  // Weighted sum, missing blue as zero; under two channels, red alone.
  always_comb begin
    gray_sum = 24'(sem_pkg::GRAY_COEF_R) * 24'(red_i)
             + 24'(sem_pkg::GRAY_COEF_G) * 24'(green_i);
    if (channel_count_i >= 3'd3) begin
      gray_sum = gray_sum + 24'(sem_pkg::GRAY_COEF_B) * 24'(blue_i);
    end
    if (channel_count_i <= 3'd1) begin
      gray = red_i;
    end else begin
      gray = gray_sum[23:16];
    end
  end

  // The previous pixel wrote the same entry at the edge this one read it
  // only for one-pixel rows; take its write data then.
  assign entry = fwd_i ? last_wr_q : ram_rdata_i;

  // The older row moves up, the new gray becomes the row above.
  assign ram_wdata_o.top = entry.mid;
  assign ram_wdata_o.mid = gray;

  // Window shifts left by one column per pixel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (valid_i) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= entry.top;
      win_q[1][2] <= entry.mid;
      win_q[2][2] <= gray;
    end
  end

  // Last write data, for the forwarding path.
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      last_wr_q <= ram_wdata_o;
    end
  end

  // Sobel gradients as differences of two non-negative sums.
  logic [9:0]  gx_p, gx_n, gy_p, gy_n;
  logic [9:0]  gx_abs, gy_abs;
  logic [10:0] mag_sum;
  logic [8:0]  mag_q4;

  always_comb begin
    gx_p = 10'(win_q[0][2]) + 10'({win_q[1][2], 1'b0}) + 10'(win_q[2][2]);
    gx_n = 10'(win_q[0][0]) + 10'({win_q[1][0], 1'b0}) + 10'(win_q[2][0]);
    gy_p = 10'(win_q[2][0]) + 10'({win_q[2][1], 1'b0}) + 10'(win_q[2][2]);
    gy_n = 10'(win_q[0][0]) + 10'({win_q[0][1], 1'b0}) + 10'(win_q[0][2]);
    gx_abs = (gx_p >= gx_n) ? (gx_p - gx_n) : (gx_n - gx_p);
    gy_abs = (gy_p >= gy_n) ? (gy_p - gy_n) : (gy_n - gy_p);
    mag_sum = 11'(gx_abs) + 11'(gy_abs);
    mag_q4 = mag_sum[10:2];
    magnitude_o = mag_q4[8] ? sem_pkg::EDGE_MAX : mag_q4[7:0];
  end

endmodule

[rtl/sem_out_fifo.sv]
// Result queue that takes up to three beats at once and hands out one.
// Keeps a reservation count so that accepted pixels always find room. Uses sem_pkg.
module sem_out_fifo (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic [1:0]                                   reserve_i,
  input  logic [sem_pkg::RES_PER_ITEM-1:0]             push_valid_i,
  input  sem_pkg::result_t [sem_pkg::RES_PER_ITEM-1:0] push_data_i,
  input  logic                                         pop_i,
  output logic                                         can_reserve_o,
  output logic                                         head_valid_o,
  output sem_pkg::result_t                             head_o
);

  localparam int unsigned Depth = sem_pkg::FIFO_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  sem_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d, occ_q, occ_d;
  logic [PtrW-1:0]  offset [sem_pkg::RES_PER_ITEM];
  logic [CntW-1:0]  push_cnt;

  // Pack the valid beats of one pixel into consecutive slots, in order.
  always_comb begin
    push_cnt = '0;
    for (int k = 0; k < sem_pkg::RES_PER_ITEM; k++) begin
      offset[k] = PtrW'(push_cnt);
      push_cnt = push_cnt + CntW'(push_valid_i[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < sem_pkg::RES_PER_ITEM; k++) begin
      if (push_valid_i[k]) begin
        mem_q[wr_ptr_q + offset[k]] <= push_data_i[k];
      end
    end
  end

  // Pointers, stored count, and stored-plus-reserved count.
  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_cnt);
    rd_ptr_d = rd_ptr_q + PtrW'(pop_i);
    cnt_d    = cnt_q + push_cnt - CntW'(pop_i);
    occ_d    = occ_q + CntW'(reserve_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      occ_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      occ_q    <= occ_d;
    end
  end

  assign can_reserve_o = (occ_q <= CntW'(Depth - sem_pkg::RES_PER_ITEM));
  assign head_valid_o  = (cnt_q != '0);
  assign head_o        = mem_q[rd_ptr_q];

`ifndef SYNTH
  // Stored beats never outrun their reservations.
  a_cnt_le_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= occ_q)
    else $error("result queue holds more beats than were reserved");

  // Reservations never exceed the queue.
  a_occ_le_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CntW'(Depth))
    else $error("result queue over-reserved");

  // A push always lands in free slots.
  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt != '0) |-> (cnt_q + push_cnt <= CntW'(Depth)))
    else $error("result queue overflow");
`endif

endmodule

[tb/sobel_edge_magnitude_stream_test.sv]
// Self-checking testbench for sobel_edge_magnitude_stream: pixel frames go in,
// edge beats are predicted here and compared field by field as they come out.
// Depends on sem_pkg and the RTL of the block only.
module sobel_edge_magnitude_stream_test;

  localparam int unsigned MAX_W = 1024;
  localparam int unsigned MAX_H = 4096;

  // One expected result beat.
  typedef struct packed {
    sem_pkg::row_t row;
    sem_pkg::col_t col;
    sem_pkg::pix_t value;
    logic          last;
  } edge_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // red, green, blue
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // out_row, out_col, edge_value
  logic        m_axis_tlast;   // frame_last
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data_i;

  sobel_edge_magnitude_stream dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Stimulus and scoreboard state.
  logic [23:0]  pending_pixels[$];
  edge_beat_t   expected_edges[$];
  int unsigned  pixels_queued = 0;
  int unsigned  pixels_taken = 0;
  int unsigned  fail_count = 0;
  bit           pixel_done = 1'b0;
  bit           idle_on = 1'b1;
  int unsigned  src_hold = 0;
  int unsigned  sink_hold = 0;

  // Shadow copy of the block: registers, line stores, window and position.
  logic [10:0]   img_width;
  logic [12:0]   img_height;
  logic [2:0]    channel_count;
  sem_pkg::pix_t line_two_up[MAX_W];
  sem_pkg::pix_t line_one_up[MAX_W];
  sem_pkg::pix_t nbhd[3][3];
  int unsigned   cur_row;
  int unsigned   cur_col;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic sem_pkg::pix_t gray_of(logic [23:0] pix);
    int unsigned r, g, b;
    r = pix[7:0];
    g = pix[15:8];
    b = pix[23:16];
    if (channel_count <= 3'd1) return sem_pkg::pix_t'(r);
    if (channel_count == 3'd2) b = 0;
    return sem_pkg::pix_t'((sem_pkg::GRAY_COEF_R * r + sem_pkg::GRAY_COEF_G * g +
                            sem_pkg::GRAY_COEF_B * b) >> 16);
  endfunction

  // Sum of absolute Sobel gradients over the window, divided by four, capped.
  function automatic sem_pkg::pix_t window_edge();
    int w[3][3];
    int gx, gy, m;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        w[i][j] = int'(nbhd[i][j]);
    gx = (w[0][2] + 2 * w[1][2] + w[2][2]) - (w[0][0] + 2 * w[1][0] + w[2][0]);
    gy = (w[2][0] + 2 * w[2][1] + w[2][2]) - (w[0][0] + 2 * w[0][1] + w[0][2]);
    if (gx < 0) gx = -gx;
    if (gy < 0) gy = -gy;
    m = (gx + gy) / 4;
    return (m > 255) ? sem_pkg::EDGE_MAX : sem_pkg::pix_t'(m);
  endfunction

  function automatic void push_edge(int unsigned row, int unsigned col,
                                    sem_pkg::pix_t value, logic last);
    edge_beat_t beat;
    beat.row   = sem_pkg::row_t'(row);
    beat.col   = sem_pkg::col_t'(col);
    beat.value = value;
    beat.last  = last;
    expected_edges.push_back(beat);
  endfunction

  // Advances the shadow state by one pixel and queues the beats it releases.
  function automatic void predict_edges(logic [23:0] pix);
    int unsigned   w, h, r, c;
    sem_pkg::pix_t gray, e;
    bit            big;
    w    = clamp_dim(img_width, MAX_W);
    h    = clamp_dim(img_height, MAX_H);
    r    = cur_row;
    c    = cur_col;
    gray = gray_of(pix);
    big  = (w >= 3) && (h >= 3);

    for (int i = 0; i < 3; i++) begin
      nbhd[i][0] = nbhd[i][1];
      nbhd[i][1] = nbhd[i][2];
    end
    nbhd[0][2] = line_two_up[c];
    nbhd[1][2] = line_one_up[c];
    nbhd[2][2] = gray;
    line_two_up[c] = line_one_up[c];
    line_one_up[c] = gray;

    // The pixel up and to the left is now complete.
    if (r >= 1 && c >= 1) begin
      e = '0;
      if (big && r - 1 >= 1 && r + 1 <= h && c - 1 >= 1 && c + 1 <= w)
        e = window_edge();
      push_edge(r - 1, c - 1, e, 1'b0);
    end
    // Right border pixel of the row above.
    if (r >= 1 && c + 1 == w)
      push_edge(r - 1, c, '0, 1'b0);
    // Bottom row leaves as it arrives.
    if (r + 1 == h)
      push_edge(r, c, '0, (c + 1 == w));

    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    cur_row = r;
    cur_col = c;
  endfunction

  // Pixel source: one beat at a time from the pending queue, with random gaps.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || pixel_done)) begin
      pixel_done = 1'b0;
      if (src_hold != 0) begin
        src_hold--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_pixels.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        src_hold = $urandom_range(0, 10);
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_pixels.pop_front();
      end
    end
  end

  // Accepted pixels feed the predictor.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predict_edges(s_axis_tdata);
      pixels_taken++;
      pixel_done = 1'b1;
    end
  end

  // Result sink with random stall bursts.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sink_hold != 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        sink_hold = $urandom_range(0, 10);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Each result beat is checked against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    edge_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_edges.size() == 0) begin
        $error("unexpected result beat: row %0d col %0d edge %0d",
               m_axis_tdata[11:0], m_axis_tdata[21:12], m_axis_tdata[29:22]);
        fail_count++;
      end else begin
        want = expected_edges.pop_front();
        if (m_axis_tdata[11:0] !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, m_axis_tdata[11:0]);
          fail_count++;
        end
        if (m_axis_tdata[21:12] !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, m_axis_tdata[21:12]);
          fail_count++;
        end
        if (m_axis_tdata[29:22] !== want.value) begin
          $error("edge_value: expected %0d, got %0d", want.value, m_axis_tdata[29:22]);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("frame_last: expected %0d, got %0d", want.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  // One register write; the frame restarts in the shadow model as well.
  task automatic write_reg(sem_pkg::cfg_idx_e idx, logic [sem_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      sem_pkg::CFG_IMG_WIDTH:     img_width = value[10:0];
      sem_pkg::CFG_IMG_HEIGHT:    img_height = value[12:0];
      sem_pkg::CFG_CHANNEL_COUNT: channel_count = value[2:0];
      default: ;
    endcase
    cur_row = 0;
    cur_col = 0;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned ch);
    write_reg(sem_pkg::CFG_IMG_WIDTH, sem_pkg::CFG_DATA_W'(w));
    write_reg(sem_pkg::CFG_IMG_HEIGHT, sem_pkg::CFG_DATA_W'(h));
    write_reg(sem_pkg::CFG_CHANNEL_COUNT, sem_pkg::CFG_DATA_W'(ch));
  endtask

  task automatic queue_pixel(logic [23:0] pix);
    pending_pixels.push_back(pix);
    pixels_queued++;
  endtask

  // Random pixel: full-range noise, or low contrast around a base level so
  // that the edge value lands below the cap.
  task automatic queue_random(int unsigned n, bit smooth);
    int unsigned base;
    base = $urandom_range(0, 232);
    for (int unsigned k = 0; k < n; k++) begin
      if (smooth)
        queue_pixel({8'(base + $urandom_range(0, 23)), 8'(base + $urandom_range(0, 23)),
                     8'(base + $urandom_range(0, 23))});
      else
        queue_pixel(24'($urandom));
    end
  endtask

  // Waits until every pixel is taken and every beat checked, then lets the
  // pipeline run dry so that pixels without results have left it too.
  task automatic settle();
    while (pixels_taken != pixels_queued || expected_edges.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned w, h, ch, n, rand_pixels;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = sem_pkg::CFG_IMG_WIDTH;
    cfg_data_i    = '0;
    img_width     = sem_pkg::IMG_WIDTH_RST;
    img_height    = sem_pkg::IMG_HEIGHT_RST;
    channel_count = sem_pkg::CHANNEL_COUNT_RST;
    cur_row       = 0;
    cur_col       = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        nbhd[i][j] = '0;
    for (int k = 0; k < MAX_W; k++) begin
      line_two_up[k] = '0;
      line_one_up[k] = '0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset geometry: a few pixels of the first row give no beats.
    queue_random(6, 1'b0);
    settle();

    // Single channel 3x3 frame whose centre saturates the edge value.
    set_frame(3, 3, 1);
    queue_pixel(24'hA5_5A_00);
    queue_pixel(24'hFF_FF_00);
    queue_pixel(24'h00_00_00);
    queue_pixel(24'h3C_C3_00);
    queue_pixel(24'h00_00_00);
    queue_pixel(24'h00_00_FF);
    queue_pixel(24'hFF_00_00);
    queue_pixel(24'h00_FF_FF);
    queue_pixel(24'h81_7E_FF);
    settle();

    // Three channels with extreme colors.
    set_frame(4, 3, 3);
    queue_pixel(24'h00_00_00);
    queue_pixel(24'hFF_FF_FF);
    queue_pixel(24'h00_00_FF);
    queue_pixel(24'h00_FF_00);
    queue_pixel(24'hFF_00_00);
    queue_pixel(24'hFF_FF_FF);
    queue_random(6, 1'b0);
    settle();

    // Random geometries, whole frames plus a partial one.
    rand_pixels = 0;
    while (rand_pixels < 150) begin
      w  = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
      h  = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
      ch = $urandom_range(0, 7);
      set_frame(w, h, ch);
      n = clamp_dim(w, MAX_W) * clamp_dim(h, MAX_H) * $urandom_range(1, 2) +
          $urandom_range(0, clamp_dim(w, MAX_W));
      queue_random(n, $urandom_range(0, 1));
      rand_pixels += n;
      settle();
    end

    // Register extremes: zero sizes, tallest column, saturated width.
    set_frame(0, 0, 0);
    queue_random(4, 1'b0);
    settle();
    set_frame(1, 8191, 7);
    queue_random(12, 1'b0);
    settle();
    set_frame(2047, 1, 4);
    queue_random(24, 1'b0);
    settle();

    // A whole frame and a bit at full rate on both sides.
    idle_on = 1'b0;
    set_frame(8, 6, 3);
    queue_random(52, 1'b1);
    while (pixels_taken != pixels_queued || expected_edges.size() != 0)
      @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // Watchdog.
  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule

[sobel_edge_magnitude_stream.f]
rtl/sem_pkg.sv
rtl/sem_ram.sv
rtl/sem_window.sv
rtl/sem_out_fifo.sv
rtl/sobel_edge_magnitude_stream.sv
tb/sobel_edge_magnitude_stream_test.sv
